// File: rtl/hndp_pkg.sv
`timescale 1ns / 1ps

package hndp_pkg;

	// character codes
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F = 8'h46;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F = 8'h66;
	localparam logic [7:0] CHAR_UPPER_X = 8'h58;
	localparam logic [7:0] CHAR_LOWER_X = 8'h78;
	localparam logic [7:0] CHAR_UNDER  = 8'h5F;

	// largest decimal value accepted
	localparam logic [30:0] DEC_LIMIT = 31'h7FFF_FFFF;

	// character position codes
	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_BODY   = 2'd2;

	typedef struct packed {
		logic [1:0]  char_position;
		logic        hex_alive;
		logic        hex_digit_seen;
		logic [63:0] hex_accum;
		logic        hex_overflowed;
		logic        dec_alive;
		logic        dec_digit_seen;
		logic [30:0] dec_accum;
		logic        dec_overflowed;
	} track_t;

	typedef struct packed {
		logic [63:0] number_value;
		logic        parse_ok;
	} result_t;

	localparam track_t TRACK_RESET = '{
		char_position:  POS_FIRST,
		hex_alive:      1'b1,
		hex_digit_seen: 1'b0,
		hex_accum:      64'd0,
		hex_overflowed: 1'b0,
		dec_alive:      1'b1,
		dec_digit_seen: 1'b0,
		dec_accum:      31'd0,
		dec_overflowed: 1'b0
	};

endpackage

// File: rtl/hndp_track.sv
`timescale 1ns / 1ps

module hndp_track (
	input  hndp_pkg::track_t  cur,
	input  logic [7:0]        char_code,
	output hndp_pkg::track_t  nxt,
	output hndp_pkg::result_t res
);
	import hndp_pkg::*;

	logic        is_dec;
	logic        is_upper;
	logic        is_lower;
	logic        is_hex;
	logic        is_under;
	logic [3:0]  nibble;
	logic [3:0]  dec_digit;
	logic [34:0] dec_sum;

	// character classes
	assign is_dec   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign is_upper = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
	assign is_lower = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
	assign is_hex   = is_dec || is_upper || is_lower;
	assign is_under = (char_code == CHAR_UNDER);

	always_comb begin
		if (is_dec)
			nibble = 4'(char_code - CHAR_ZERO);
		else if (is_upper)
			nibble = 4'(char_code - CHAR_UPPER_A + 8'd10);
		else
			nibble = 4'(char_code - CHAR_LOWER_A + 8'd10);
	end

	// times ten as two shifts and an add
	assign dec_digit = 4'(char_code - CHAR_ZERO);
	assign dec_sum   = {cur.dec_accum, 3'b000} + {2'b00, cur.dec_accum, 1'b0}
		+ {31'd0, dec_digit};

	// next track state
	always_comb begin
		nxt = cur;
		if (cur.hex_alive) begin
			if (cur.char_position == POS_FIRST) begin
				if (char_code != CHAR_ZERO) nxt.hex_alive = 1'b0;
			end else if (cur.char_position == POS_SECOND) begin
				if (char_code != CHAR_LOWER_X && char_code != CHAR_UPPER_X)
					nxt.hex_alive = 1'b0;
			end else if (!is_under) begin
				if (!is_hex) begin
					nxt.hex_alive = 1'b0;
				end else begin
					nxt.hex_digit_seen = 1'b1;
					if (!cur.hex_overflowed) begin
						if (cur.hex_accum[63:60] != 4'd0)
							nxt.hex_overflowed = 1'b1;
						else
							nxt.hex_accum = {cur.hex_accum[59:0], nibble};
					end
				end
			end
		end
		if (cur.dec_alive && !is_under) begin
			if (is_dec) begin
				nxt.dec_digit_seen = 1'b1;
				if (!cur.dec_overflowed) begin
					if (dec_sum > {4'd0, DEC_LIMIT})
						nxt.dec_overflowed = 1'b1;
					else
						nxt.dec_accum = dec_sum[30:0];
				end
			end else begin
				nxt.dec_alive = 1'b0;
			end
		end
		if (cur.char_position != POS_BODY)
			nxt.char_position = cur.char_position + 2'd1;
	end

	// answer from the updated tracks
	always_comb begin
		if (nxt.hex_alive && nxt.hex_digit_seen && !nxt.hex_overflowed) begin
			res.number_value = nxt.hex_accum;
			res.parse_ok     = 1'b1;
		end else if (nxt.dec_alive && nxt.dec_digit_seen && !nxt.dec_overflowed) begin
			res.number_value = {33'd0, nxt.dec_accum};
			res.parse_ok     = 1'b1;
		end else begin
			res.number_value = 64'd0;
			res.parse_ok     = 1'b0;
		end
	end

endmodule

// File: rtl/hex_or_decimal_text_to_number_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata                  | tuser       | tlast
// s_      | in  | [7:0] char_code        | -           | last_char
// m_      | out | [63:0] number_value    | [0] parse_ok| -
//
// one character word per cycle; a word is registered, then the hex and
// decimal tracks update in one pass and a result word lands in the output
// register when a last character moves on from the input stage.
// reset returns both tracks to the start of a string and empties all stages.
// input stalls only when a last character sits in the input stage while a
// result word is still waiting downstream.

module hex_or_decimal_text_to_number_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] number_value
	output logic [0:0]  m_tuser    // [0] parse_ok
);
	import hndp_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       go_s1;
	logic       load_out;
	track_t     track_q;
	track_t     track_nxt;
	result_t    res;
	result_t    out_q;
	logic       out_valid_q;

	// input stage moves on unless a result word has nowhere to go
	assign go_s1    = !last_s1 || !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || go_s1;
	assign load_out = valid_s1 && last_s1 && go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			last_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) char_s1 <= s_tdata;
	end

	hndp_track u_track (
		.cur       (track_q),
		.char_code (char_s1),
		.nxt       (track_nxt),
		.res       (res)
	);

	// track state, cleared after each last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= TRACK_RESET;
		end else if (valid_s1 && go_s1) begin
			track_q <= last_s1 ? TRACK_RESET : track_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= res;
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q.number_value;
	assign m_tuser[0] = out_q.parse_ok;

endmodule

// File: rtl/hndp_checker.sv
`timescale 1ns / 1ps

module hndp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// a failed parse reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
		else $error("failed parse with nonzero value");

	// input back-pressure only while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with free output");

	// output stays valid for the cycle after a stall
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> m_tvalid)
		else $error("result word lost after input stall");

endmodule

bind hex_or_decimal_text_to_number_top hndp_checker u_hndp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/tb_hex_or_decimal_text_to_number_top.sv
`timescale 1ns / 1ps

module tb_hex_or_decimal_text_to_number_top;
	import hndp_pkg::*;

	localparam int ITEM_GOAL      = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;

	typedef enum int {
		TXT_HEX,
		TXT_DEC,
		TXT_HEX_EDGE,
		TXT_DEC_EDGE,
		TXT_BROKEN,
		TXT_NOISE,
		TXT_BARE,
		TXT_KIND_COUNT
	} text_kind_e;

	typedef struct packed {
		logic [7:0]  code;
		logic        last;
		logic        typed;
		logic [63:0] value;
		logic        ok;
	} directed_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_code
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [63:0] number_value
	logic [0:0]  m_tuser;   // [0] parse_ok

	track_t      text_track;
	result_t     parse_answers [$];
	logic [7:0]  text_chars [$];
	int          sent_chars;
	int          mismatches;
	int          quiet_cycles;
	bit          send_calm;
	bit          recv_calm;
	bit          long_hold_req;
	bit          hold_done;

	// short strings covering prefixes, underscores, high codes and failures
	directed_row_t directed_rows [24] = '{
		'{CHAR_ZERO, 1'b1, 1'b1, 64'd0, 1'b1},
		'{CHAR_ZERO, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_LOWER_X, 1'b1, 1'b1, 64'd0, 1'b0},
		'{CHAR_UNDER, 1'b1, 1'b1, 64'd0, 1'b0},
		'{CHAR_ZERO, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_UPPER_X, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_LOWER_A, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_UPPER_F, 1'b1, 1'b0, 64'd0, 1'b0},
		'{CHAR_UNDER, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_ZERO + 8'd1, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_UNDER, 1'b1, 1'b1, 64'd1, 1'b1},
		'{CHAR_ZERO, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_UNDER, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_ZERO + 8'd1, 1'b1, 1'b0, 64'd0, 1'b0},
		'{CHAR_ZERO, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_LOWER_X, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_ZERO, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_UNDER, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_UPPER_F, 1'b1, 1'b0, 64'd0, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 64'd0, 1'b0},
		'{8'h80, 1'b1, 1'b1, 64'd0, 1'b0},
		'{8'h00, 1'b1, 1'b1, 64'd0, 1'b0},
		'{CHAR_NINE, 1'b0, 1'b0, 64'd0, 1'b0},
		'{CHAR_LOWER_F + 8'd1, 1'b1, 1'b1, 64'd0, 1'b0}
	};

	hex_or_decimal_text_to_number_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// advance both readings by one character; returns 1 when a result is due
	function automatic bit parse_step(input logic [7:0] code, input logic last,
			output result_t answer);
		logic [3:0]  nib;
		bit          is_hex;
		logic [34:0] dec_next;
		is_hex = 1'b1;
		nib    = 4'd0;
		if (code >= CHAR_ZERO && code <= CHAR_NINE)
			nib = 4'(code - CHAR_ZERO);
		else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_F)
			nib = 4'(code - CHAR_UPPER_A + 8'd10);
		else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_F)
			nib = 4'(code - CHAR_LOWER_A + 8'd10);
		else
			is_hex = 1'b0;

		// hex reading: prefix in the first two places, then digits or underscores
		if (text_track.hex_alive) begin
			case (text_track.char_position)
				POS_FIRST: begin
					if (code != CHAR_ZERO) text_track.hex_alive = 1'b0;
				end
				POS_SECOND: begin
					if (code != CHAR_LOWER_X && code != CHAR_UPPER_X)
						text_track.hex_alive = 1'b0;
				end
				default: begin
					if (code != CHAR_UNDER) begin
						if (!is_hex) begin
							text_track.hex_alive = 1'b0;
						end else begin
							text_track.hex_digit_seen = 1'b1;
							if (!text_track.hex_overflowed) begin
								if (text_track.hex_accum[63:60] != 4'd0)
									text_track.hex_overflowed = 1'b1;
								else
									text_track.hex_accum = {text_track.hex_accum[59:0], nib};
							end
						end
					end
				end
			endcase
		end

		// decimal reading
		if (text_track.dec_alive && code != CHAR_UNDER) begin
			if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
				text_track.dec_digit_seen = 1'b1;
				if (!text_track.dec_overflowed) begin
					dec_next = {4'd0, text_track.dec_accum} * 35'd10 + {31'd0, nib};
					if (dec_next > {4'd0, DEC_LIMIT})
						text_track.dec_overflowed = 1'b1;
					else
						text_track.dec_accum = dec_next[30:0];
				end
			end else begin
				text_track.dec_alive = 1'b0;
			end
		end

		if (text_track.char_position != POS_BODY)
			text_track.char_position = text_track.char_position + 2'd1;

		answer = '0;
		if (!last) return 1'b0;
		if (text_track.hex_alive && text_track.hex_digit_seen && !text_track.hex_overflowed) begin
			answer.number_value = text_track.hex_accum;
			answer.parse_ok     = 1'b1;
		end else if (text_track.dec_alive && text_track.dec_digit_seen &&
				!text_track.dec_overflowed) begin
			answer.number_value = {33'd0, text_track.dec_accum};
			answer.parse_ok     = 1'b1;
		end
		text_track = TRACK_RESET;
		return 1'b1;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return CHAR_ZERO + {4'd0, v};
		return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'd0, v - 4'd10};
	endfunction

	// digit with an occasional underscore in front
	task automatic add_digit(input logic [7:0] c);
		if ($urandom_range(0, 7) == 0) text_chars.push_back(CHAR_UNDER);
		text_chars.push_back(c);
	endtask

	// build one string of the given flavor into text_chars
	task automatic make_text(input text_kind_e kind);
		int                n;
		int                pick;
		int                i;
		logic [63:0]       v;
		string             digits;
		text_chars.delete();
		case (kind)
			TXT_HEX, TXT_HEX_EDGE: begin
				text_chars.push_back(CHAR_ZERO);
				text_chars.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 4)) add_digit(CHAR_ZERO);
				if (kind == TXT_HEX) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
					repeat (n) add_digit(hex_char(4'($urandom_range(0, 15))));
				end else begin
					pick = $urandom_range(0, 3);
					v = {$urandom, $urandom};
					if (pick == 0) v = '1;
					if (pick == 3) v[63:60] = 4'($urandom_range(1, 15));
					// one nibble too many pushes the value past 64 bits
					if (pick == 1) add_digit(hex_char(4'($urandom_range(1, 15))));
					for (i = 15; i >= 0; i--) add_digit(hex_char(v[4 * i +: 4]));
				end
				if ($urandom_range(0, 7) == 0) text_chars.push_back(CHAR_UNDER);
			end
			TXT_DEC: begin
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 3)) add_digit(CHAR_ZERO);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 6);
				repeat (n) add_digit(CHAR_ZERO + 8'($urandom_range(0, 9)));
				if ($urandom_range(0, 7) == 0) text_chars.push_back(CHAR_UNDER);
			end
			TXT_DEC_EDGE: begin
				pick = $urandom_range(0, 4);
				case (pick)
					0:       v = 64'd2147483647;
					1:       v = 64'd2147483648;
					2:       v = 64'd0;
					3:       v = 64'd9999999999;
					default: v = 64'($urandom_range(0, 32'h7FFF_FFFF));
				endcase
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3)) add_digit(CHAR_ZERO);
				digits = $sformatf("%0d", v);
				for (i = 0; i < digits.len(); i++) add_digit(digits[i]);
			end
			TXT_BROKEN: begin
				make_text($urandom_range(0, 1) ? TXT_HEX : TXT_DEC);
				text_chars[$urandom_range(0, text_chars.size() - 1)] = 8'($urandom_range(0, 255));
			end
			TXT_NOISE: begin
				repeat ($urandom_range(1, 4)) text_chars.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				// strings with no digit beyond a bare 0x or 0X prefix
				pick = $urandom_range(0, 2);
				if (pick != 0) begin
					text_chars.push_back(CHAR_ZERO);
					text_chars.push_back(pick == 1 ? CHAR_LOWER_X : CHAR_UPPER_X);
				end
				repeat ($urandom_range(pick == 0 ? 1 : 0, 3)) text_chars.push_back(CHAR_UNDER);
			end
		endcase
	endtask

	function automatic text_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 32) return TXT_HEX;
		if (r < 64) return TXT_DEC;
		if (r < 68) return TXT_HEX_EDGE;
		if (r < 72) return TXT_DEC_EDGE;
		if (r < 87) return TXT_BROKEN;
		if (r < 95) return TXT_NOISE;
		return TXT_BARE;
	endfunction

	// offer one character word and record the answer it is due to give
	task automatic put_char(input logic [7:0] code, input logic last, input logic given,
			input result_t given_result);
		result_t answer;
		int      gap;
		gap = send_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sent_chars++;
		if (parse_step(code, last, answer))
			parse_answers.push_back(given ? given_result : answer);
	endtask

	task automatic send_text(input text_kind_e kind);
		make_text(kind);
		foreach (text_chars[i])
			put_char(text_chars[i], i == text_chars.size() - 1, 1'b0, '0);
	endtask

	task automatic wait_for_answers();
		s_tvalid <= 1'b0;
		while (parse_answers.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// stimulus
	initial begin
		result_t typed_result;
		int      k;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		send_calm     = 1'b0;
		recv_calm     = 1'b0;
		long_hold_req = 1'b0;
		hold_done     = 1'b0;
		sent_chars    = 0;
		mismatches    = 0;
		text_track    = TRACK_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			typed_result.number_value = directed_rows[i].value;
			typed_result.parse_ok     = directed_rows[i].ok;
			put_char(directed_rows[i].code, directed_rows[i].last, directed_rows[i].typed,
				typed_result);
		end

		// every flavor once, then a weighted mix
		for (k = 0; k < TXT_KIND_COUNT; k++) send_text(text_kind_e'(k));
		while (sent_chars < ITEM_GOAL) begin
			if (!hold_done && sent_chars >= 500) begin
				// receiver holds off while the sender keeps offering
				hold_done     = 1'b1;
				long_hold_req = 1'b1;
				send_calm     = 1'b1;
				repeat (12) send_text(TXT_DEC);
				send_calm = 1'b0;
				wait_for_answers();
			end
			recv_calm = (sent_chars >= 1100 && sent_chars < 1400);
			send_calm = recv_calm;
			send_text(pick_kind());
		end

		send_calm = 1'b0;
		wait_for_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_hex_or_decimal_text_to_number_top: clean");
		else
			$display("tb_hex_or_decimal_text_to_number_top: errors");
		$finish;
	end

	// result side ready with random stalls and one long hold
	initial begin
		int stall_left;
		m_tready   = 1'b0;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!recv_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	// compare each result word with the oldest pending answer
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parse_answers.size() == 0) begin
				$error("result word with no answer pending: number_value %h parse_ok %b",
					m_tdata, m_tuser[0]);
				mismatches++;
			end else begin
				want = parse_answers.pop_front();
				if (m_tdata !== want.number_value) begin
					$error("number_value expected %h actual %h", want.number_value, m_tdata);
					mismatches++;
				end
				if (m_tuser[0] !== want.parse_ok) begin
					$error("parse_ok expected %b actual %b", want.parse_ok, m_tuser[0]);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_hex_or_decimal_text_to_number_top: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
